// File: design/blas_pkg.sv
// Shared widths, constants, register codes and helpers of the launch angle solver.
package blas_pkg;

	localparam int FRAC_BITS    = 16;
	localparam int SPEED_FRAC   = 8;
	localparam int EXP_P        = 2 * FRAC_BITS;
	localparam int EXP_R        = 2 * SPEED_FRAC;
	localparam int EXP_M        = 2 * SPEED_FRAC + 1;
	localparam int NORM_BITS    = 30;
	localparam int CORDIC_STEPS = 30;

	localparam int DIST_W = 24;
	localparam int HGT_W  = 24;
	localparam int SPD_W  = 16;
	localparam int GRAV_W = 21;
	localparam int ANG_W  = 18;

	localparam int PB_W   = 2 * SPD_W;
	localparam int RB_W   = GRAV_W + DIST_W;
	localparam int MB_W   = GRAV_W + HGT_W;
	localparam int PW_W   = PB_W + EXP_P;
	localparam int RW_W   = RB_W + EXP_R;
	localparam int MW_W   = MB_W + EXP_M;
	localparam int LEN_W  = 7;
	localparam int TERM_W = NORM_BITS;
	localparam int PROD_W = 2 * TERM_W;
	localparam int SQ_W   = PROD_W + 2;
	localparam int NUM_W  = PROD_W + 2;
	localparam int ROOT_W = SQ_W / 2;
	localparam int SQRT_STEPS = SQ_W / 2;
	localparam int PS_W   = ROOT_W + 1;
	localparam int DEN_W  = TERM_W + PS_W;
	localparam int NORM_W = 64;
	localparam int CW     = NORM_BITS + 4;
	localparam int Z_W    = 34;

	localparam int ANGLE_MAX = 2 ** (ANG_W - 1) - 1;
	localparam int ANGLE_MIN = -(2 ** (ANG_W - 1));

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = GRAV_W;

	localparam int PREP_STAGES   = 5;
	localparam int CORDIC_STAGES = 3 + CORDIC_STEPS + 1;
	localparam int LATENCY       = PREP_STAGES + SQRT_STEPS + 1 + CORDIC_STAGES + 1;

	localparam logic [GRAV_W-1:0]       GRAVITY_RST  = GRAV_W'(642253);
	localparam logic signed [ANG_W-1:0] WIN_LOW_RST  = ANG_W'(-45752);
	localparam logic signed [ANG_W-1:0] WIN_HIGH_RST = ANG_W'(11438);

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_GRAVITY  = 2'd0,
		CFG_WIN_LOW  = 2'd1,
		CFG_WIN_HIGH = 2'd2
	} cfg_reg_t;

	localparam logic [31:0] ATAN_Q30 [CORDIC_STEPS] = '{
		32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76,
		32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD,
		32'h000FFFFF, 32'h0007FFFF, 32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF,
		32'h00007FFF, 32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
		32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F, 32'h0000003F,
		32'h0000001F, 32'h0000000F, 32'h00000008, 32'h00000004, 32'h00000002
	};

	// Sideband that rides along the square root pipeline.
	typedef struct packed {
		logic              fail;
		logic [TERM_W-1:0] p;
		logic [TERM_W-1:0] r;
		logic [NUM_W-1:0]  num;
	} sq_side_t;

	function automatic logic [LEN_W-1:0] bit_len64(input logic [63:0] v);
		logic [LEN_W-1:0] n;
		n = '0;
		for (int i = 0; i < 64; i++) begin
			if (v[i]) begin
				n = LEN_W'(i + 1);
			end
		end
		return n;
	endfunction

endpackage

// File: design/blas_prep.sv
// Front end: products, block scaling and discriminant of the quadratic.
module blas_prep (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	input  logic [blas_pkg::DIST_W-1:0]  distance,
	input  logic [blas_pkg::HGT_W-1:0]   hgt,
	input  logic [blas_pkg::SPD_W-1:0]   speed,
	input  logic [blas_pkg::GRAV_W-1:0]  gravity,
	output logic                         out_valid,
	output logic [blas_pkg::SQ_W-1:0]    radicand,
	output blas_pkg::sq_side_t           side
);

	logic [blas_pkg::HGT_W-1:0] habs;

	logic                        valid_s1, hneg_s1, zero_s1;
	logic [blas_pkg::PB_W-1:0]   pb_s1;
	logic [blas_pkg::RB_W-1:0]   rb_s1;
	logic [blas_pkg::MB_W-1:0]   mb_s1;

	logic                        valid_s2, hneg_s2, zero_s2;
	logic [blas_pkg::PB_W-1:0]   pb_s2;
	logic [blas_pkg::RB_W-1:0]   rb_s2;
	logic [blas_pkg::MB_W-1:0]   mb_s2;
	logic [blas_pkg::LEN_W-1:0]  k_s2;
	logic [blas_pkg::LEN_W-1:0]  lp, lr, lm, n_max;

	logic                        valid_s3, hneg_s3, zero_s3;
	logic [blas_pkg::TERM_W-1:0] p_s3, r_s3, m_s3;

	logic                        valid_s4, hneg_s4, zero_s4;
	logic [blas_pkg::TERM_W-1:0] p_s4, r_s4;
	logic [blas_pkg::PROD_W-1:0] pp_s4, rr_s4, pm_s4;

	logic [blas_pkg::SQ_W:0]     pp_w, rr_w, pm_w, sq;
	logic [blas_pkg::NUM_W-1:0]  num;

	logic                        valid_s5, fail_s5;
	logic [blas_pkg::SQ_W-1:0]   sq_s5;
	logic [blas_pkg::NUM_W-1:0]  num_s5;
	logic [blas_pkg::TERM_W-1:0] p_s5, r_s5;

	assign habs = hgt[blas_pkg::HGT_W-1] ? (~hgt + 1'b1) : hgt;

	// Bit lengths of the three scaled terms and the largest of them.
	always_comb begin
		lp = blas_pkg::bit_len64(64'(pb_s1)) + blas_pkg::LEN_W'(blas_pkg::EXP_P);
		lr = blas_pkg::bit_len64(64'(rb_s1)) + blas_pkg::LEN_W'(blas_pkg::EXP_R);
		lm = (mb_s1 == '0) ? '0 :
			blas_pkg::bit_len64(64'(mb_s1)) + blas_pkg::LEN_W'(blas_pkg::EXP_M);
		n_max = (lp > lr) ? lp : lr;
		if (lm > n_max) begin
			n_max = lm;
		end
	end

	always_comb begin
		pp_w = (blas_pkg::SQ_W + 1)'(pp_s4);
		rr_w = (blas_pkg::SQ_W + 1)'(rr_s4);
		pm_w = (blas_pkg::SQ_W + 1)'(pm_s4);
		sq   = hneg_s4 ? (pp_w + rr_w - pm_w) : (pp_w + rr_w + pm_w);
		num  = hneg_s4 ? blas_pkg::NUM_W'(rr_w - pm_w) : blas_pkg::NUM_W'(rr_w + pm_w);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		pb_s1   <= blas_pkg::PB_W'(speed) * blas_pkg::PB_W'(speed);
		rb_s1   <= blas_pkg::RB_W'(gravity) * blas_pkg::RB_W'(distance);
		mb_s1   <= blas_pkg::MB_W'(gravity) * blas_pkg::MB_W'(habs);
		hneg_s1 <= hgt[blas_pkg::HGT_W-1];
		zero_s1 <= (distance == '0) || (speed == '0) || (gravity == '0);

		pb_s2   <= pb_s1;
		rb_s2   <= rb_s1;
		mb_s2   <= mb_s1;
		hneg_s2 <= hneg_s1;
		zero_s2 <= zero_s1;
		// Shift that brings the largest term below bit NORM_BITS.
		k_s2    <= (n_max > blas_pkg::LEN_W'(blas_pkg::NORM_BITS)) ?
			(n_max - blas_pkg::LEN_W'(blas_pkg::NORM_BITS)) : '0;

		// Align the top bit of the largest term just below bit NORM_BITS.
		p_s3    <= blas_pkg::TERM_W'((blas_pkg::PW_W'(pb_s2) << blas_pkg::EXP_P) >> k_s2);
		r_s3    <= blas_pkg::TERM_W'((blas_pkg::RW_W'(rb_s2) << blas_pkg::EXP_R) >> k_s2);
		m_s3    <= blas_pkg::TERM_W'((blas_pkg::MW_W'(mb_s2) << blas_pkg::EXP_M) >> k_s2);
		hneg_s3 <= hneg_s2;
		zero_s3 <= zero_s2;

		pp_s4   <= blas_pkg::PROD_W'(p_s3) * blas_pkg::PROD_W'(p_s3);
		rr_s4   <= blas_pkg::PROD_W'(r_s3) * blas_pkg::PROD_W'(r_s3);
		pm_s4   <= blas_pkg::PROD_W'(p_s3) * blas_pkg::PROD_W'(m_s3);
		p_s4    <= p_s3;
		r_s4    <= r_s3;
		hneg_s4 <= hneg_s3;
		zero_s4 <= zero_s3;

		sq_s5   <= sq[blas_pkg::SQ_W-1:0];
		fail_s5 <= zero_s4 | sq[blas_pkg::SQ_W];
		num_s5  <= num;
		p_s5    <= p_s4;
		r_s5    <= r_s4;
	end

	assign out_valid = valid_s5;
	assign radicand  = sq_s5;
	assign side      = '{fail: fail_s5, p: p_s5, r: r_s5, num: num_s5};

endmodule

// File: design/blas_sqrt.sv
// Pipelined integer square root, one result bit per stage.
module blas_sqrt (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	input  logic [blas_pkg::SQ_W-1:0]   radicand,
	input  blas_pkg::sq_side_t          side_in,
	output logic                        out_valid,
	output logic [blas_pkg::ROOT_W-1:0] root,
	output blas_pkg::sq_side_t          side_out
);

	localparam int N = blas_pkg::SQRT_STEPS;

	logic                       vld_s  [N+1];
	logic [blas_pkg::SQ_W-1:0]  rem_s  [N+1];
	logic [blas_pkg::SQ_W-1:0]  root_s [N+1];
	blas_pkg::sq_side_t         side_s [N+1];

	assign vld_s[0]  = in_valid;
	assign rem_s[0]  = radicand;
	assign root_s[0] = '0;
	assign side_s[0] = side_in;

	for (genvar j = 0; j < N; j++) begin : g_step
		localparam logic [blas_pkg::SQ_W:0] BIT = (blas_pkg::SQ_W + 1)'(1) << (2 * (N - 1 - j));
		logic [blas_pkg::SQ_W:0] trial;
		logic                    take;

		assign trial = (blas_pkg::SQ_W + 1)'(root_s[j]) + BIT;
		assign take  = (blas_pkg::SQ_W + 1)'(rem_s[j]) >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[j+1] <= 1'b0;
			end else begin
				vld_s[j+1] <= vld_s[j];
			end
		end

		always_ff @(posedge clk) begin
			side_s[j+1] <= side_s[j];
			if (take) begin
				rem_s[j+1]  <= blas_pkg::SQ_W'((blas_pkg::SQ_W + 1)'(rem_s[j]) - trial);
				root_s[j+1] <= (root_s[j] >> 1) + blas_pkg::SQ_W'(BIT);
			end else begin
				rem_s[j+1]  <= rem_s[j];
				root_s[j+1] <= root_s[j] >> 1;
			end
		end
	end

	assign out_valid = vld_s[N];
	assign root      = root_s[N][blas_pkg::ROOT_W-1:0];
	assign side_out  = side_s[N];

endmodule

// File: design/blas_cordic.sv
// Pipelined atan2 for x >= 0: normalize, vectoring CORDIC, round and saturate.
module blas_cordic (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	input  logic [blas_pkg::DEN_W-1:0]        xm,
	input  logic [blas_pkg::DEN_W-1:0]        ym,
	input  logic                              yneg,
	input  logic                              tag_in,
	output logic                              out_valid,
	output logic signed [blas_pkg::ANG_W-1:0] angle,
	output logic                              tag_out
);

	localparam int NW = blas_pkg::NORM_W;
	localparam int NS = blas_pkg::CORDIC_STEPS;
	localparam int CW = blas_pkg::CW;
	localparam int ZW = blas_pkg::Z_W;

	typedef struct packed {
		logic [NW-1:0] x;
		logic [NW-1:0] y;
		logic [NW-1:0] mx;
	} nrm_t;

	function automatic nrm_t nrm_shift(input nrm_t a, input int s);
		nrm_t b;
		b = a;
		if ((a.mx >> (NW - s)) == '0) begin
			b.x  = a.x << s;
			b.y  = a.y << s;
			b.mx = a.mx << s;
		end
		return b;
	endfunction

	nrm_t nrm_in;
	nrm_t nrm_s1, nrm_s2, nrm_s3;
	logic valid_s1, valid_s2, valid_s3;
	logic zero_s1, zero_s2, zero_s3;
	logic yneg_s1, yneg_s2, yneg_s3;
	logic tag_s1, tag_s2, tag_s3;

	logic                 cv_s  [NS+1];
	logic signed [CW-1:0] cx_s  [NS+1];
	logic signed [CW-1:0] cy_s  [NS+1];
	logic signed [ZW-1:0] cz_s  [NS+1];
	logic                 czr_s [NS+1];
	logic                 ctg_s [NS+1];

	logic signed [ZW-1:0] z_rnd, a_sh;
	logic signed [blas_pkg::ANG_W-1:0] a_sat;
	logic                 valid_s34, tag_s34;
	logic signed [blas_pkg::ANG_W-1:0] angle_s34;

	assign nrm_in.x  = NW'(xm);
	assign nrm_in.y  = NW'(ym);
	assign nrm_in.mx = (xm > ym) ? NW'(xm) : NW'(ym);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			valid_s2  <= 1'b0;
			valid_s3  <= 1'b0;
			valid_s34 <= 1'b0;
		end else begin
			valid_s1  <= in_valid;
			valid_s2  <= valid_s1;
			valid_s3  <= valid_s2;
			valid_s34 <= cv_s[NS];
		end
	end

	// Left-normalize the larger magnitude to the top bit.
	always_ff @(posedge clk) begin
		nrm_s1  <= nrm_shift(nrm_shift(nrm_in, 32), 16);
		zero_s1 <= (nrm_in.mx == '0);
		yneg_s1 <= yneg;
		tag_s1  <= tag_in;
		nrm_s2  <= nrm_shift(nrm_shift(nrm_s1, 8), 4);
		zero_s2 <= zero_s1;
		yneg_s2 <= yneg_s1;
		tag_s2  <= tag_s1;
		nrm_s3  <= nrm_shift(nrm_shift(nrm_s2, 2), 1);
		zero_s3 <= zero_s2;
		yneg_s3 <= yneg_s2;
		tag_s3  <= tag_s2;
	end

	assign cv_s[0]  = valid_s3;
	assign cx_s[0]  = CW'(nrm_s3.x[NW-1 -: blas_pkg::NORM_BITS]);
	assign cy_s[0]  = yneg_s3 ? -CW'(nrm_s3.y[NW-1 -: blas_pkg::NORM_BITS])
	                          :  CW'(nrm_s3.y[NW-1 -: blas_pkg::NORM_BITS]);
	assign cz_s[0]  = '0;
	assign czr_s[0] = zero_s3;
	assign ctg_s[0] = tag_s3;

	for (genvar i = 0; i < NS; i++) begin : g_rot
		logic signed [CW-1:0] dx, dy;
		logic signed [ZW-1:0] ang;

		assign dx  = cy_s[i] >>> i;
		assign dy  = cx_s[i] >>> i;
		assign ang = ZW'(blas_pkg::ATAN_Q30[i]);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				cv_s[i+1] <= 1'b0;
			end else begin
				cv_s[i+1] <= cv_s[i];
			end
		end

		always_ff @(posedge clk) begin
			czr_s[i+1] <= czr_s[i];
			ctg_s[i+1] <= ctg_s[i];
			if (!cy_s[i][CW-1]) begin
				cx_s[i+1] <= cx_s[i] + dx;
				cy_s[i+1] <= cy_s[i] - dy;
				cz_s[i+1] <= cz_s[i] + ang;
			end else begin
				cx_s[i+1] <= cx_s[i] - dx;
				cy_s[i+1] <= cy_s[i] + dy;
				cz_s[i+1] <= cz_s[i] - ang;
			end
		end
	end

	// Round half up from Q30 to the output scale, then clamp.
	always_comb begin
		z_rnd = cz_s[NS] + ZW'(1 << (29 - blas_pkg::FRAC_BITS));
		a_sh  = z_rnd >>> (30 - blas_pkg::FRAC_BITS);
		if (a_sh > ZW'(blas_pkg::ANGLE_MAX)) begin
			a_sat = blas_pkg::ANG_W'(blas_pkg::ANGLE_MAX);
		end else if (a_sh < ZW'(blas_pkg::ANGLE_MIN)) begin
			a_sat = blas_pkg::ANG_W'(blas_pkg::ANGLE_MIN);
		end else begin
			a_sat = a_sh[blas_pkg::ANG_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		angle_s34 <= czr_s[NS] ? '0 : a_sat;
		tag_s34   <= ctg_s[NS];
	end

	assign out_valid = valid_s34;
	assign angle     = angle_s34;
	assign tag_out   = tag_s34;

endmodule

// File: design/ballistic_launch_angle_solve_core.sv
// Top level of the projectile launch angle solver.
//
// Usage: drive horizontal_distance, height_difference and projectile_speed
// and raise start for one cycle per target. busy is always low, so a beat
// is taken at every rising edge with start high, back to back without gaps.
// Each beat yields exactly one result beat: strobe is high for one cycle
// with launch_angle, angle_valid and root_choice. The receiver cannot hold
// results off; it must take the beat at the edge that ends that cycle.
// Throughput is one target per cycle. A target passes the five front-end
// stages, the 31 stages of the square root (one root bit per stage), one
// denominator multiply, the 34 stages of each CORDIC lane (normalize,
// 30 vectoring steps, round) and the output register.
// Configuration: cfg_we writes cfg_data into register cfg_index at once
// (0 gravity, 1 low window bound, 2 high window bound); write only while
// no target is in flight. An index beyond the list is dropped.
// Reset clears all valid bits and reloads the register defaults; no result
// beat leaves until a new target is taken.
module ballistic_launch_angle_solve_core (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   start,
	output logic                                   busy,
	input  logic [blas_pkg::DIST_W-1:0]            horizontal_distance,
	input  logic signed [blas_pkg::HGT_W-1:0]      height_difference,
	input  logic [blas_pkg::SPD_W-1:0]             projectile_speed,
	input  logic                                   cfg_we,
	input  logic [blas_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [blas_pkg::CFG_DATA_W-1:0]        cfg_data,
	output logic                                   strobe,
	output logic signed [blas_pkg::ANG_W-1:0]      launch_angle,
	output logic                                   angle_valid,
	output logic                                   root_choice
);

	// Configuration registers.
	logic [blas_pkg::GRAV_W-1:0]       gravity_q;
	logic signed [blas_pkg::ANG_W-1:0] win_low_q, win_high_q;

	// Front end to square root.
	logic                       prep_valid;
	logic [blas_pkg::SQ_W-1:0]  prep_radicand;
	blas_pkg::sq_side_t         prep_side;

	// Square root to denominator stage.
	logic                        sqrt_valid;
	logic [blas_pkg::ROOT_W-1:0] sqrt_root;
	blas_pkg::sq_side_t          sqrt_side;
	logic [blas_pkg::PS_W-1:0]   ps;

	// Denominator stage.
	logic                        valid_s1, fail_s1;
	logic [blas_pkg::DEN_W-1:0]  den_s1;
	logic [blas_pkg::NUM_W-1:0]  num_s1;
	logic [blas_pkg::TERM_W-1:0] r_s1;
	logic [blas_pkg::PS_W-1:0]   ps_s1;
	logic                        num_neg;
	logic [blas_pkg::DEN_W-1:0]  num_mag;

	// CORDIC lanes.
	logic                              plus_valid, plus_fail;
	logic signed [blas_pkg::ANG_W-1:0] plus_angle, minus_angle;
	logic                              plus_in, minus_in;

	// Output register.
	logic                              strobe_q, angle_valid_q, root_choice_q;
	logic signed [blas_pkg::ANG_W-1:0] launch_angle_q;

	assign busy = 1'b0;

	// Take register writes at once; drop unknown indexes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gravity_q  <= blas_pkg::GRAVITY_RST;
			win_low_q  <= blas_pkg::WIN_LOW_RST;
			win_high_q <= blas_pkg::WIN_HIGH_RST;
		end else if (cfg_we) begin
			unique case (blas_pkg::cfg_reg_t'(cfg_index))
				blas_pkg::CFG_GRAVITY:  gravity_q  <= cfg_data;
				blas_pkg::CFG_WIN_LOW:  win_low_q  <= cfg_data[blas_pkg::ANG_W-1:0];
				blas_pkg::CFG_WIN_HIGH: win_high_q <= cfg_data[blas_pkg::ANG_W-1:0];
				default: ;
			endcase
		end
	end

	blas_prep u_prep (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (start & ~busy),
		.distance  (horizontal_distance),
		.hgt       (height_difference),
		.speed     (projectile_speed),
		.gravity   (gravity_q),
		.out_valid (prep_valid),
		.radicand  (prep_radicand),
		.side      (prep_side)
	);

	blas_sqrt u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (prep_valid),
		.radicand  (prep_radicand),
		.side_in   (prep_side),
		.out_valid (sqrt_valid),
		.root      (sqrt_root),
		.side_out  (sqrt_side)
	);

	// Denominator of the plus root: r * (p + s).
	assign ps = blas_pkg::PS_W'(sqrt_side.p) + blas_pkg::PS_W'(sqrt_root);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= sqrt_valid;
		end
	end

	always_ff @(posedge clk) begin
		den_s1  <= blas_pkg::DEN_W'(sqrt_side.r) * blas_pkg::DEN_W'(ps);
		num_s1  <= sqrt_side.num;
		r_s1    <= sqrt_side.r;
		ps_s1   <= ps;
		fail_s1 <= sqrt_side.fail;
	end

	// Split the signed numerator into sign and magnitude for the lane.
	assign num_neg = num_s1[blas_pkg::NUM_W-1];
	assign num_mag = num_neg ? blas_pkg::DEN_W'(~num_s1 + 1'b1) : blas_pkg::DEN_W'(num_s1);

	blas_cordic u_cordic_plus (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (valid_s1),
		.xm        (den_s1),
		.ym        (num_mag),
		.yneg      (num_neg),
		.tag_in    (fail_s1),
		.out_valid (plus_valid),
		.angle     (plus_angle),
		.tag_out   (plus_fail)
	);

	// Minus root: atan2(-(p + s), r). Valid and tag follow the plus lane.
	blas_cordic u_cordic_minus (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (valid_s1),
		.xm        (blas_pkg::DEN_W'(r_s1)),
		.ym        (blas_pkg::DEN_W'(ps_s1)),
		.yneg      (1'b1),
		.tag_in    (fail_s1),
		.out_valid (),
		.angle     (minus_angle),
		.tag_out   ()
	);

	// Prefer the plus root when it falls strictly inside the window.
	assign plus_in  = (plus_angle > win_low_q) && (plus_angle < win_high_q);
	assign minus_in = (minus_angle > win_low_q) && (minus_angle < win_high_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= plus_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (plus_fail || !(plus_in || minus_in)) begin
			angle_valid_q  <= 1'b0;
			launch_angle_q <= '0;
			root_choice_q  <= 1'b0;
		end else begin
			angle_valid_q  <= 1'b1;
			launch_angle_q <= plus_in ? plus_angle : minus_angle;
			root_choice_q  <= ~plus_in;
		end
	end

	assign strobe       = strobe_q;
	assign launch_angle = launch_angle_q;
	assign angle_valid  = angle_valid_q;
	assign root_choice  = root_choice_q;

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##(blas_pkg::LATENCY) strobe)
		else $error("accepted beat did not produce a result on time");

	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> $past(start && !busy, blas_pkg::LATENCY))
		else $error("result beat without a matching accepted beat");

	a_clear_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && !angle_valid) |-> (launch_angle == '0 && !root_choice))
		else $error("invalid result carries nonzero fields");

endmodule

// File: tb/launch_angle_checker.sv
// Checker for the launch angle solver: watches target and result beats, predicts and compares.
module launch_angle_checker (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   start,
	input  logic                                   busy,
	input  logic [blas_pkg::DIST_W-1:0]            horizontal_distance,
	input  logic signed [blas_pkg::HGT_W-1:0]      height_difference,
	input  logic [blas_pkg::SPD_W-1:0]             projectile_speed,
	input  logic                                   cfg_we,
	input  logic [blas_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [blas_pkg::CFG_DATA_W-1:0]        cfg_data,
	input  logic                                   strobe,
	input  logic signed [blas_pkg::ANG_W-1:0]      launch_angle,
	input  logic                                   angle_valid,
	input  logic                                   root_choice,
	output int                                     fail_count,
	output int                                     pending
);
	timeunit 1ns;
	timeprecision 1ps;
	import blas_pkg::*;

	typedef struct packed {
		logic signed [ANG_W-1:0] angle;
		logic                    valid;
		logic                    choice;
	} solution_t;

	logic [GRAV_W-1:0]       grav_q;
	logic signed [ANG_W-1:0] win_lo_q;
	logic signed [ANG_W-1:0] win_hi_q;
	solution_t               solutions_due[$];

	localparam longint ATAN_TAB [CORDIC_STEPS] = '{
		64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76,
		64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD,
		64'h000FFFFF, 64'h0007FFFF, 64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF,
		64'h00007FFF, 64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
		64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F, 64'h0000003F,
		64'h0000001F, 64'h0000000F, 64'h00000008, 64'h00000004, 64'h00000002
	};

	function automatic int bits_used(input longint unsigned v);
		int n;
		n = 0;
		while (v != 0) begin
			n++;
			v >>= 1;
		end
		return n;
	endfunction

	// >>> on a signed longint is a floor shift
	function automatic longint cordic_angle(input longint unsigned xm_in, input longint y_in);
		longint unsigned xm, ym, mx;
		longint x, y, z, dx, dy, a;
		int len;
		bit yneg;
		xm = xm_in;
		yneg = y_in < 0;
		ym = yneg ? longint'(-y_in) : y_in;
		mx = xm > ym ? xm : ym;
		if (mx == 0) begin
			return 0;
		end
		len = bits_used(mx);
		if (len > NORM_BITS) begin
			xm >>= len - NORM_BITS;
			ym >>= len - NORM_BITS;
		end else begin
			xm <<= NORM_BITS - len;
			ym <<= NORM_BITS - len;
		end
		x = xm;
		y = yneg ? -longint'(ym) : longint'(ym);
		z = 0;
		for (int i = 0; i < CORDIC_STEPS; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (y >= 0) begin
				x += dx; y -= dy; z += ATAN_TAB[i];
			end else begin
				x -= dx; y += dy; z -= ATAN_TAB[i];
			end
		end
		a = (z + (longint'(1) << (29 - FRAC_BITS))) >>> (30 - FRAC_BITS);
		if (a > ANGLE_MAX) a = ANGLE_MAX;
		if (a < ANGLE_MIN) a = ANGLE_MIN;
		return a;
	endfunction

	function automatic longint unsigned scaled(input longint unsigned base, input int e,
			input int k);
		if (base == 0) return 0;
		if (e >= k) return base << (e - k);
		if (k - e >= 64) return 0;
		return base >> (k - e);
	endfunction

	function automatic longint unsigned int_sqrt(input longint unsigned n_in);
		longint unsigned n, r, b;
		n = n_in;
		r = 0;
		b = 64'h4000_0000_0000_0000;
		while (b > n) b >>= 2;
		while (b != 0) begin
			if (n >= r + b) begin
				n -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function automatic solution_t solve_angle(input logic [DIST_W-1:0] d,
			input logic signed [HGT_W-1:0] h, input logic [SPD_W-1:0] v);
		solution_t res;
		longint unsigned pb, rb, mb, p, r, mm, s, den;
		longint m, sq, num, ang, ha;
		int lp, lr, lm, n, k;
		res = '0;
		if (d == 0 || v == 0 || grav_q == 0) return res;
		ha = h;
		if (ha < 0) ha = -ha;
		pb = longint'(v) * longint'(v);
		rb = longint'(grav_q) * longint'(d);
		mb = longint'(grav_q) * ha;
		lp = bits_used(pb) + EXP_P;
		lr = bits_used(rb) + EXP_R;
		lm = mb != 0 ? bits_used(mb) + EXP_M : 0;
		n = lp > lr ? lp : lr;
		if (lm > n) n = lm;
		k = n > NORM_BITS ? n - NORM_BITS : 0;
		p = scaled(pb, EXP_P, k);
		r = scaled(rb, EXP_R, k);
		mm = scaled(mb, EXP_M, k);
		m = h < 0 ? -longint'(mm) : longint'(mm);
		sq = longint'(p * p) + longint'(r * r) + longint'(p) * m;
		if (sq < 0) return res;
		s = int_sqrt(sq);
		num = longint'(r * r) + longint'(p) * m;
		den = r * (p + s);
		ang = cordic_angle(den, num);
		if (ang > win_lo_q && ang < win_hi_q) begin
			res.angle = ANG_W'(ang);
			res.valid = 1'b1;
			return res;
		end
		ang = cordic_angle(r, -longint'(p + s));
		if (ang > win_lo_q && ang < win_hi_q) begin
			res.angle = ANG_W'(ang);
			res.valid = 1'b1;
			res.choice = 1'b1;
		end
		return res;
	endfunction

	task automatic report_mismatch(input string what);
		$display("mismatch at %0t: %s", $realtime, what);
		fail_count++;
	endtask

	initial fail_count = 0;
	assign pending = solutions_due.size();

	always @(posedge clk or negedge arst_n) begin
		solution_t want;
		if (!arst_n) begin
			grav_q <= GRAVITY_RST;
			win_lo_q <= WIN_LOW_RST;
			win_hi_q <= WIN_HIGH_RST;
		end else begin
			if (strobe) begin
				if (solutions_due.size() == 0) begin
					report_mismatch("result beat with nothing expected");
				end else begin
					want = solutions_due.pop_front();
					if (angle_valid !== want.valid)
						report_mismatch($sformatf("angle_valid %b want %b", angle_valid,
							want.valid));
					if (launch_angle !== want.angle)
						report_mismatch($sformatf("launch_angle %0d want %0d", launch_angle,
							want.angle));
					if (root_choice !== want.choice)
						report_mismatch($sformatf("root_choice %b want %b", root_choice,
							want.choice));
				end
			end
			if (start && !busy)
				solutions_due.push_back(solve_angle(horizontal_distance, height_difference,
					projectile_speed));
			if (cfg_we) begin
				case (cfg_index)
					CFG_GRAVITY: begin
						grav_q <= cfg_data;
					end
					CFG_WIN_LOW: begin
						win_lo_q <= cfg_data[ANG_W-1:0];
					end
					CFG_WIN_HIGH: begin
						win_hi_q <= cfg_data[ANG_W-1:0];
					end
					default: begin
					end
				endcase
			end
		end
	end

endmodule

// File: tb/testbench.sv
// Stimulus and verdict for the launch angle solver.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import blas_pkg::*;

	logic                    clk;
	logic                    arst_n;
	logic                    start;
	logic                    busy;
	logic [DIST_W-1:0]       horizontal_distance;
	logic signed [HGT_W-1:0] height_difference;
	logic [SPD_W-1:0]        projectile_speed;
	logic                    cfg_we;
	logic [CFG_IDX_W-1:0]    cfg_index;
	logic [CFG_DATA_W-1:0]   cfg_data;
	logic                    strobe;
	logic signed [ANG_W-1:0] launch_angle;
	logic                    angle_valid;
	logic                    root_choice;
	int                      fail_count;
	int                      pending;
	longint                  cycle_count;

	// generous: ~800 beats with gaps, drains and latency, many times over
	localparam longint CYCLE_LIMIT = 400000;

	ballistic_launch_angle_solve_core uut (.*);

	launch_angle_checker checker_i (.*);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Watchdog: a hung pipeline must not stall the run.
	initial begin
		cycle_count = 0;
		forever begin
			@(posedge clk);
			cycle_count++;
			if (cycle_count > CYCLE_LIMIT) begin
				$display("[FAIL] regression broken");
				$finish;
			end
		end
	end

	// Present one target beat and hold until it is taken.
	task automatic send_target(input logic [DIST_W-1:0] d, input logic [HGT_W-1:0] h,
			input logic [SPD_W-1:0] v);
		start <= 1'b1;
		horizontal_distance <= d;
		height_difference <= h;
		projectile_speed <= v;
		do @(posedge clk); while (busy);
	endtask

	task automatic idle_cycles(input int n);
		start <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	// Drain: wait for every expected beat, then let the pipeline settle
	// before touching a register.
	task automatic drain_pipe;
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (LATENCY + 8) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Random target shaped so that most beats land in the solvable region:
	// moderate distances and speeds, height a fraction of the distance.
	task automatic send_random_target;
		logic [DIST_W-1:0] d;
		logic [HGT_W-1:0]  h;
		logic [SPD_W-1:0]  v;
		int                pick;
		pick = $urandom_range(0, 9);
		if (pick < 7) begin
			d = DIST_W'($urandom_range(1 << 16, 200 << 16));
			h = $urandom_range(0, 1) ? HGT_W'(d >> $urandom_range(1, 6)) :
				-HGT_W'(d >> $urandom_range(1, 6));
			v = SPD_W'($urandom_range(10 << 8, 100 << 8));
		end else begin
			d = DIST_W'($urandom);
			h = HGT_W'($urandom);
			v = SPD_W'($urandom);
			if ($urandom_range(0, 5) == 0) d = 0;
			if ($urandom_range(0, 5) == 0) v = 0;
		end
		send_target(d, h, v);
	endtask

	task automatic random_phase(input int count);
		int left;
		left = count;
		while (left > 0) begin
			// burst of back to back beats, then a gap (sometimes none)
			for (int b = $urandom_range(1, 20); b > 0 && left > 0; b--) begin
				send_random_target();
				left--;
			end
			if ($urandom_range(0, 3) != 0) idle_cycles($urandom_range(1, 12));
		end
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		horizontal_distance = '0;
		height_difference = '0;
		projectile_speed = '0;
		cfg_we = 1'b0;
		cfg_index = CFG_GRAVITY;
		cfg_data = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: field extremes, zero distance, zero speed, level shot,
		// negative discriminant, steep targets up and down
		send_target('0, '0, '0);
		send_target('0, 24'sd65536, 16'd5000);
		send_target(24'd655360, '0, '0);
		send_target(24'hFFFFFF, 24'sh7FFFFF, 16'hFFFF);
		send_target(24'hFFFFFF, 24'sh800000, 16'hFFFF);
		send_target(24'd1, 24'sh7FFFFF, 16'd1);
		send_target(24'd1, 24'sh800000, 16'd1);
		send_target(24'd655360, '0, 16'd5120);
		send_target(24'd6553600, 24'sd6553600, 16'd2560);
		send_target(24'd6553600, -24'sd1310720, 16'd20000);
		send_target(24'd65536, -24'sd6553600, 16'd25600);
		send_target(24'd65536, 24'sd6553600, 16'd25600);
		send_target(24'hFFFFFF, '0, 16'd1);
		send_target(24'd1, '0, 16'hFFFF);
		send_target(24'h555555, 24'shAAAAAA, 16'h5555);
		send_target(24'hAAAAAA, 24'sh555555, 16'hAAAA);
		drain_pipe();

		// zero gravity: every target invalid
		write_reg(CFG_GRAVITY, '0);
		send_target(24'd655360, 24'sd65536, 16'd5120);
		send_target(24'd6553600, -24'sd65536, 16'd10000);
		drain_pipe();

		// widest window, max gravity
		write_reg(CFG_GRAVITY, '1);
		write_reg(CFG_WIN_LOW, CFG_DATA_W'(-18'sd102944));
		write_reg(CFG_WIN_HIGH, CFG_DATA_W'(18'sd102944));
		random_phase(200);
		drain_pipe();

		// inverted window and random gravity, then a narrow window at default gravity
		write_reg(CFG_GRAVITY, GRAV_W'($urandom_range(1, 2097151)));
		write_reg(CFG_WIN_LOW, CFG_DATA_W'(18'sd102944));
		write_reg(CFG_WIN_HIGH, CFG_DATA_W'(-18'sd102944));
		random_phase(60);
		drain_pipe();

		write_reg(CFG_WIN_LOW, CFG_DATA_W'(-18'sd20000));
		write_reg(CFG_WIN_HIGH, CFG_DATA_W'(18'sd60000));
		write_reg(CFG_GRAVITY, GRAV_W'(642253));
		random_phase(200);
		drain_pipe();

		// back to reset defaults; an index past the list must be dropped
		write_reg(CFG_WIN_LOW, CFG_DATA_W'(WIN_LOW_RST));
		write_reg(CFG_WIN_HIGH, CFG_DATA_W'(WIN_HIGH_RST));
		cfg_we <= 1'b1;
		cfg_index <= CFG_IDX_W'(3);
		cfg_data <= '1;
		@(posedge clk);
		cfg_we <= 1'b0;
		random_phase(320);
		drain_pipe();

		if (fail_count == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
